@@ rtl/core/mlft_pkg.sv @@
// Shared types, constants and codes of the MAC learning forwarding table.
`timescale 1ns / 1ps

package mlft_pkg;

   localparam int TABLE_ENTRIES = 16;
   localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_ENTRIES - 1);

   localparam int OP_W = 2;
   localparam int MAC_W = 48;
   localparam int IP_W = 32;
   localparam int PORT_W = 16;
   localparam int KIND_W = 2;
   localparam int TIME_W = 64;
   localparam int EXPIRY_W = 16;
   localparam int GROUP_BIT = 40;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam logic [CSR_ADDR_W-1:0] CSR_EXPIRY_ADDR = CSR_ADDR_W'(0);
   localparam logic [EXPIRY_W-1:0] EXPIRY_RESET = EXPIRY_W'(5000);

   typedef enum logic [OP_W-1:0] {
      OP_LEARN  = 2'd0,
      OP_LOOKUP = 2'd1,
      OP_TICK   = 2'd2
   } op_type;

   typedef enum logic [KIND_W-1:0] {
      KIND_DONE   = 2'd0,
      KIND_SEND   = 2'd1,
      KIND_FLOOD  = 2'd2,
      KIND_REJECT = 2'd3
   } kind_type;

   typedef struct packed {
      logic [MAC_W-1:0]  mac;
      logic [IP_W-1:0]   ip;
      logic [PORT_W-1:0] udp_port;
      logic              armed;
      logic [TIME_W-1:0] deadline;
   } entry_type;

   localparam int ENTRY_W = $bits(entry_type);

endpackage

@@ rtl/core/mlft_if.sv @@
// Request and response channel interfaces of the forwarding table.
`timescale 1ns / 1ps

interface mlft_req_if;
   logic                         valid;
   logic                         ready;
   logic [mlft_pkg::OP_W-1:0]    operation;
   logic [mlft_pkg::MAC_W-1:0]   mac;
   logic [mlft_pkg::IP_W-1:0]    peer_addr;
   logic [mlft_pkg::PORT_W-1:0]  peer_port;

   modport source (output valid, output operation, output mac, output peer_addr,
                   output peer_port, input ready);
   modport sink (input valid, input operation, input mac, input peer_addr,
                 input peer_port, output ready);
endinterface

interface mlft_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mlft_pkg::KIND_W-1:0]  result_kind;
   logic [mlft_pkg::IP_W-1:0]    dest_addr;
   logic [mlft_pkg::PORT_W-1:0]  dest_port;

   modport source (output valid, output result_kind, output dest_addr,
                   output dest_port, input ready);
   modport sink (input valid, input result_kind, input dest_addr,
                 input dest_port, output ready);
endinterface

@@ rtl/core/mac_learning_forward_table.sv @@
// Top level of the MAC learning forwarding table: sequencer, scan compare and CSR.
//
//   Channel  Direction  Handshake           Carries
//   req      in         valid/ready         operation, mac, peer_addr, peer_port
//   rsp      out        valid/ready         result_kind, dest_addr, dest_port
//   csr      in/out     APB psel/penable    expiry_ms at byte address 0
//
// A learn or lookup of a unicast MAC scans the table one entry per cycle through
// the RAM read port and a single 64-bit compare unit.
// Ticks, group MACs and unused operations skip the scan and go to the final step.
// Reset clears the valid bits; there is no clearing pass.
// The next transaction is accepted while a result waits in the output register;
// the sequencer stalls only in its final step until that register is free.
`timescale 1ns / 1ps

module mac_learning_forward_table (
   input  logic                              clock,
   input  logic                              reset,
   mlft_req_if.sink                          req,
   mlft_rsp_if.source                        rsp,
   input  logic                              csr_psel,
   input  logic                              csr_penable,
   input  logic                              csr_pwrite,
   input  logic [mlft_pkg::CSR_ADDR_W-1:0]   csr_paddr,
   input  logic [mlft_pkg::CSR_DATA_W-1:0]   csr_pwdata,
   output logic [mlft_pkg::CSR_DATA_W-1:0]   csr_prdata,
   output logic                              csr_pready
);

   import mlft_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_FINISH
   } state_type;

   state_type             state_ff, state_in;
   op_type                op_ff, op_in;
   logic [MAC_W-1:0]      mac_ff, mac_in;
   logic [IP_W-1:0]       peer_addr_ff, peer_addr_in;
   logic [PORT_W-1:0]     peer_port_ff, peer_port_in;

   logic [IDX_W-1:0]      scan_idx_ff, scan_idx_in;
   logic                  issue_done_ff, issue_done_in;
   logic                  rd_vld_ff, rd_vld_in;
   logic [IDX_W-1:0]      rd_idx_ff, rd_idx_in;

   logic                  hit_ff, hit_in;
   logic [IDX_W-1:0]      hit_idx_ff, hit_idx_in;
   entry_type             hit_entry_ff, hit_entry_in;
   logic                  hit_exp_ff, hit_exp_in;
   logic                  free_ff, free_in;
   logic [IDX_W-1:0]      free_idx_ff, free_idx_in;
   logic                  exp_found_ff, exp_found_in;
   logic [IDX_W-1:0]      exp_idx_ff, exp_idx_in;

   logic [TIME_W-1:0]     now_ff, now_in;
   logic [EXPIRY_W-1:0]   expiry_ff, expiry_in;
   logic [TABLE_ENTRIES-1:0] entry_valid_ff, entry_valid_in;

   logic                  rsp_valid_ff, rsp_valid_in;
   kind_type              rsp_kind_ff, rsp_kind_in;
   logic [IP_W-1:0]       rsp_addr_ff, rsp_addr_in;
   logic [PORT_W-1:0]     rsp_port_ff, rsp_port_in;

   logic                  ram_we;
   logic [IDX_W-1:0]      ram_waddr;
   entry_type             ram_wentry;
   logic                  ram_re;
   logic [ENTRY_W-1:0]    ram_rdata;

   entry_type             rd_entry;
   logic [TIME_W-1:0]     slot_deadline;
   logic                  slot_expired;
   logic                  slot_valid;
   logic [TIME_W:0]       deadline_sum;
   logic [TIME_W-1:0]     new_deadline;
   logic                  req_fire;
   logic                  out_free;
   logic                  csr_write;
   logic                  is_group;

   mlft_ram #(
      .WIDTH (ENTRY_W),
      .DEPTH (TABLE_ENTRIES)
   ) u_entry_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wentry),
      .rd_en   (ram_re),
      .rd_addr (scan_idx_ff),
      .rd_data (ram_rdata)
   );

   assign req.ready   = (state_ff == ST_IDLE);
   assign req_fire    = req.valid && req.ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.result_kind = rsp_kind_ff;
   assign rsp.dest_addr   = rsp_addr_ff;
   assign rsp.dest_port   = rsp_port_ff;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && (csr_paddr == CSR_EXPIRY_ADDR);
   assign csr_prdata = (csr_paddr == CSR_EXPIRY_ADDR) ?
                       CSR_DATA_W'(expiry_ff) : '0;

   // The shared compare unit: an unarmed entry counts as a deadline of all ones.
   assign rd_entry      = entry_type'(ram_rdata);
   assign slot_deadline = rd_entry.armed ? rd_entry.deadline : '1;
   assign slot_expired  = (now_ff >= slot_deadline);
   assign slot_valid    = entry_valid_ff[rd_idx_ff];

   assign deadline_sum = {1'b0, now_ff} + (TIME_W + 1)'(expiry_ff);
   assign new_deadline = deadline_sum[TIME_W] ? '1 : deadline_sum[TIME_W-1:0];

   assign ram_re   = (state_ff == ST_SCAN) && !issue_done_ff;
   assign out_free = !rsp_valid_ff || rsp.ready;
   assign is_group = mac_ff[GROUP_BIT];

   always_comb begin
      state_in       = state_ff;
      op_in          = op_ff;
      mac_in         = mac_ff;
      peer_addr_in   = peer_addr_ff;
      peer_port_in   = peer_port_ff;
      scan_idx_in    = scan_idx_ff;
      issue_done_in  = issue_done_ff;
      rd_vld_in      = 1'b0;
      rd_idx_in      = scan_idx_ff;
      hit_in         = hit_ff;
      hit_idx_in     = hit_idx_ff;
      hit_entry_in   = hit_entry_ff;
      hit_exp_in     = hit_exp_ff;
      free_in        = free_ff;
      free_idx_in    = free_idx_ff;
      exp_found_in   = exp_found_ff;
      exp_idx_in     = exp_idx_ff;
      now_in         = now_ff;
      expiry_in      = csr_write ? csr_pwdata[EXPIRY_W-1:0] : expiry_ff;
      entry_valid_in = entry_valid_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_kind_in    = rsp_kind_ff;
      rsp_addr_in    = rsp_addr_ff;
      rsp_port_in    = rsp_port_ff;
      ram_we         = 1'b0;
      ram_waddr      = hit_idx_ff;
      ram_wentry     = hit_entry_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               op_in         = op_type'(req.operation);
               mac_in        = req.mac;
               peer_addr_in  = req.peer_addr;
               peer_port_in  = req.peer_port;
               scan_idx_in   = '0;
               issue_done_in = 1'b0;
               hit_in        = 1'b0;
               hit_exp_in    = 1'b0;
               free_in       = 1'b0;
               exp_found_in  = 1'b0;
               if ((op_type'(req.operation) == OP_LEARN ||
                    op_type'(req.operation) == OP_LOOKUP) && !req.mac[GROUP_BIT]) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_SCAN: begin
            if (!issue_done_ff) begin
               rd_vld_in = 1'b1;
               if (scan_idx_ff == LAST_IDX) begin
                  issue_done_in = 1'b1;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
            if (rd_vld_ff) begin
               // The lowest index wins for each kind of candidate slot.
               if (slot_valid && rd_entry.mac == mac_ff && !hit_ff) begin
                  hit_in       = 1'b1;
                  hit_idx_in   = rd_idx_ff;
                  hit_entry_in = rd_entry;
                  hit_exp_in   = slot_expired;
               end
               if (!slot_valid && !free_ff) begin
                  free_in     = 1'b1;
                  free_idx_in = rd_idx_ff;
               end
               if (slot_valid && slot_expired && !exp_found_ff) begin
                  exp_found_in = 1'b1;
                  exp_idx_in   = rd_idx_ff;
               end
               if (rd_idx_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_FINISH: begin
            if (out_free) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               rsp_kind_in  = KIND_DONE;
               rsp_addr_in  = '0;
               rsp_port_in  = '0;
               case (op_ff)
                  OP_LEARN: begin
                     if (!is_group) begin
                        if (hit_ff || free_ff || exp_found_ff) begin
                           ram_we    = 1'b1;
                           ram_waddr = hit_ff ? hit_idx_ff :
                                       (free_ff ? free_idx_ff : exp_idx_ff);
                           ram_wentry.mac      = mac_ff;
                           ram_wentry.ip       = peer_addr_ff;
                           ram_wentry.udp_port = peer_port_ff;
                           ram_wentry.armed    = 1'b0;
                           ram_wentry.deadline = '0;
                           entry_valid_in[ram_waddr] = 1'b1;
                        end else begin
                           rsp_kind_in = KIND_REJECT;
                        end
                     end
                  end
                  OP_LOOKUP: begin
                     if (hit_ff && !hit_exp_ff) begin
                        rsp_kind_in = KIND_SEND;
                        rsp_addr_in = hit_entry_ff.ip;
                        rsp_port_in = hit_entry_ff.udp_port;
                        if (!hit_entry_ff.armed) begin
                           ram_we              = 1'b1;
                           ram_wentry.armed    = 1'b1;
                           ram_wentry.deadline = new_deadline;
                        end
                     end else begin
                        rsp_kind_in = KIND_FLOOD;
                     end
                  end
                  OP_TICK: begin
                     if (now_ff != '1) begin
                        now_in = now_ff + TIME_W'(1);
                     end
                  end
                  default: begin
                     rsp_kind_in = KIND_DONE;
                  end
               endcase
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         issue_done_ff  <= 1'b0;
         rd_vld_ff      <= 1'b0;
         hit_ff         <= 1'b0;
         hit_exp_ff     <= 1'b0;
         free_ff        <= 1'b0;
         exp_found_ff   <= 1'b0;
         now_ff         <= '0;
         expiry_ff      <= EXPIRY_RESET;
         entry_valid_ff <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         issue_done_ff  <= issue_done_in;
         rd_vld_ff      <= rd_vld_in;
         hit_ff         <= hit_in;
         hit_exp_ff     <= hit_exp_in;
         free_ff        <= free_in;
         exp_found_ff   <= exp_found_in;
         now_ff         <= now_in;
         expiry_ff      <= expiry_in;
         entry_valid_ff <= entry_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      op_ff        <= op_in;
      mac_ff       <= mac_in;
      peer_addr_ff <= peer_addr_in;
      peer_port_ff <= peer_port_in;
      scan_idx_ff  <= scan_idx_in;
      rd_idx_ff    <= rd_idx_in;
      hit_idx_ff   <= hit_idx_in;
      hit_entry_ff <= hit_entry_in;
      free_idx_ff  <= free_idx_in;
      exp_idx_ff   <= exp_idx_in;
      rsp_kind_ff  <= rsp_kind_in;
      rsp_addr_ff  <= rsp_addr_in;
      rsp_port_ff  <= rsp_port_in;
   end

`ifndef SYNTHESIS
   a_reset_clears_valid: assert property (@(posedge clock)
      reset |=> entry_valid_ff == '0)
      else $error("valid bits not cleared by reset");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> state_ff != ST_IDLE)
      else $error("sequencer stayed idle after accepting a transaction");

   a_send_only_has_payload: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_kind_ff != KIND_SEND |-> rsp_addr_ff == '0 && rsp_port_ff == '0)
      else $error("destination fields set on a result that is not a send");

   a_time_monotonic: assert property (@(posedge clock) disable iff (reset)
      !reset |=> now_ff >= $past(now_ff))
      else $error("millisecond counter went backwards");

   a_write_only_when_finishing: assert property (@(posedge clock) disable iff (reset)
      ram_we |-> state_ff == ST_FINISH && out_free)
      else $error("table written outside the final step");
`endif

endmodule

@@ rtl/core/mlft_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mlft_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

@@ dv/mlft_checker.sv @@
// Checker for the forwarding table: predicts each result and compares it with the DUT.
`timescale 1ns / 1ps

module mlft_checker
   import mlft_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   mlft_req_if                   req,
   mlft_rsp_if                   rsp,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [CSR_DATA_W-1:0] csr_pwdata,
   input  logic                  csr_pready,
   output int                    failures,
   output int                    outstanding,
   output int                    sends_seen,
   output int                    floods_seen,
   output int                    rejects_seen,
   output int                    dones_seen
);

   typedef struct packed {
      kind_type          kind;
      logic [IP_W-1:0]   addr;
      logic [PORT_W-1:0] port;
   } forward_result;

   logic                slot_live [TABLE_ENTRIES];
   entry_type           slot_data [TABLE_ENTRIES];
   logic [TIME_W-1:0]   now_ms;
   logic [EXPIRY_W-1:0] expiry_setting;
   forward_result       expected_results [$];

   initial begin
      failures = 0;
      outstanding = 0;
      sends_seen = 0;
      floods_seen = 0;
      rejects_seen = 0;
      dones_seen = 0;
   end

   // An entry that was never looked up has no deadline and only ages out once the
   // clock has saturated.
   function automatic logic slot_aged(int i);
      logic [TIME_W-1:0] limit;
      limit = slot_data[i].armed ? slot_data[i].deadline : '1;
      return now_ms >= limit;
   endfunction

   function automatic int slot_of(logic [MAC_W-1:0] mac);
      int i;
      int hit;
      hit = -1;
      for (i = TABLE_ENTRIES - 1; i >= 0; i--)
         if (slot_live[i] && slot_data[i].mac == mac)
            hit = i;
      return hit;
   endfunction

   function automatic forward_result forward_decision(logic [OP_W-1:0] op,
                                                      logic [MAC_W-1:0] mac,
                                                      logic [IP_W-1:0] addr,
                                                      logic [PORT_W-1:0] port);
      forward_result r;
      int            pick;
      int            i;
      logic [TIME_W:0] sum;
      r.kind = KIND_DONE;
      r.addr = '0;
      r.port = '0;
      case (op)
         OP_LEARN: begin
            if (!mac[GROUP_BIT]) begin
               pick = slot_of(mac);
               for (i = 0; i < TABLE_ENTRIES; i++)
                  if (pick < 0 && !slot_live[i])
                     pick = i;
               for (i = 0; i < TABLE_ENTRIES; i++)
                  if (pick < 0 && slot_aged(i))
                     pick = i;
               if (pick < 0) begin
                  r.kind = KIND_REJECT;
               end else begin
                  slot_live[pick] = 1'b1;
                  slot_data[pick].mac = mac;
                  slot_data[pick].ip = addr;
                  slot_data[pick].udp_port = port;
                  slot_data[pick].armed = 1'b0;
                  slot_data[pick].deadline = '0;
               end
            end
         end
         OP_LOOKUP: begin
            r.kind = KIND_FLOOD;
            if (!mac[GROUP_BIT]) begin
               pick = slot_of(mac);
               if (pick >= 0 && !slot_aged(pick)) begin
                  if (!slot_data[pick].armed) begin
                     sum = {1'b0, now_ms} + (TIME_W + 1)'(expiry_setting);
                     slot_data[pick].deadline = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
                     slot_data[pick].armed = 1'b1;
                  end
                  r.kind = KIND_SEND;
                  r.addr = slot_data[pick].ip;
                  r.port = slot_data[pick].udp_port;
               end
            end
         end
         OP_TICK: begin
            if (now_ms != '1)
               now_ms = now_ms + 1'b1;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin : watch
      forward_result want;
      int            i;
      if (reset) begin
         for (i = 0; i < TABLE_ENTRIES; i++)
            slot_live[i] = 1'b0;
         now_ms = '0;
         expiry_setting = EXPIRY_RESET;
         expected_results.delete();
         outstanding <= 0;
      end else begin
         if (csr_psel && csr_penable && csr_pwrite && csr_pready
             && csr_paddr == CSR_EXPIRY_ADDR)
            expiry_setting = csr_pwdata[EXPIRY_W-1:0];

         // The result is matched before a new request is queued, so that a result
         // arriving with nothing outstanding cannot pair with that request.
         if (rsp.valid && rsp.ready) begin
            case (rsp.result_kind)
               KIND_SEND:   sends_seen++;
               KIND_FLOOD:  floods_seen++;
               KIND_REJECT: rejects_seen++;
               default:     dones_seen++;
            endcase
            if (expected_results.size() == 0) begin
               $display("%0t: unexpected transaction, expected none, got kind %0d addr %h port %h",
                        $time, rsp.result_kind, rsp.dest_addr, rsp.dest_port);
               failures++;
            end else begin
               want = expected_results.pop_front();
               if (rsp.result_kind !== want.kind) begin
                  $display("%0t: result_kind mismatch, expected %0d, got %0d",
                           $time, want.kind, rsp.result_kind);
                  failures++;
               end
               if (rsp.dest_addr !== want.addr) begin
                  $display("%0t: dest_addr mismatch, expected %h, got %h",
                           $time, want.addr, rsp.dest_addr);
                  failures++;
               end
               if (rsp.dest_port !== want.port) begin
                  $display("%0t: dest_port mismatch, expected %h, got %h",
                           $time, want.port, rsp.dest_port);
                  failures++;
               end
            end
         end

         if (req.valid && req.ready)
            expected_results.push_back(forward_decision(req.operation, req.mac,
                                                        req.peer_addr, req.peer_port));
         outstanding <= expected_results.size();
      end
   end

endmodule

@@ dv/tb_top.sv @@
// Testbench top of the forwarding table: clock, reset, stimulus, flow control and verdict.
`timescale 1ns / 1ps

module tb_top;
   import mlft_pkg::*;

   localparam int PHASES = 6;
   localparam int ITEMS_PER_PHASE = 70;
   localparam int POOL_SIZE = 20;
   localparam int LONG_HOLD = 80;
   localparam int DRAIN_CYCLES = TABLE_ENTRIES + 8;
   localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
   localparam logic [MAC_W-1:0] GROUP_MASK = MAC_W'(1) << GROUP_BIT;
   localparam logic [MAC_W-1:0] GROUP_ONLY = 48'h0100_0000_0000;
   localparam logic [MAC_W-1:0] ALL_ONES_MAC = 48'hFFFF_FFFF_FFFF;
   localparam logic [MAC_W-1:0] TOP_UNICAST = 48'hFEFF_FFFF_FFFF;
   localparam logic [MAC_W-1:0] STATION_A = 48'h0200_5E10_2030;

   logic clock = 1'b0;
   logic reset = 1'b1;

   mlft_req_if req_bus ();
   mlft_rsp_if rsp_bus ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   int failures;
   int outstanding;
   int sends_seen;
   int floods_seen;
   int rejects_seen;
   int dones_seen;

   int req_idle_pct = 0;
   int rsp_idle_pct = 0;
   int hold_requests = 0;
   int holds_served = 0;
   int items_offered = 0;

   logic [MAC_W-1:0]    station_pool [POOL_SIZE];
   logic [EXPIRY_W-1:0] expiry_plan [PHASES] = '{16'd65535, 16'd3, 16'd1, 16'd0, 16'd20, 16'd0};

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   mac_learning_forward_table i_dut (
      .clock       (clock),
      .reset       (reset),
      .req         (req_bus),
      .rsp         (rsp_bus),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   mlft_checker i_checker (
      .clock        (clock),
      .reset        (reset),
      .req          (req_bus),
      .rsp          (rsp_bus),
      .csr_psel     (csr_psel),
      .csr_penable  (csr_penable),
      .csr_pwrite   (csr_pwrite),
      .csr_paddr    (csr_paddr),
      .csr_pwdata   (csr_pwdata),
      .csr_pready   (csr_pready),
      .failures     (failures),
      .outstanding  (outstanding),
      .sends_seen   (sends_seen),
      .floods_seen  (floods_seen),
      .rejects_seen (rejects_seen),
      .dones_seen   (dones_seen)
   );

   // Result side: random back-pressure, plus a long hold-off whenever one is asked for.
   initial begin
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (hold_requests > holds_served) begin
            holds_served++;
            rsp_bus.ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
         end
         rsp_bus.ready <= ($urandom_range(0, 99) >= rsp_idle_pct);
      end
   end

   task automatic offer(input logic [OP_W-1:0] op, input logic [MAC_W-1:0] mac,
                        input logic [IP_W-1:0] addr, input logic [PORT_W-1:0] port);
      while ($urandom_range(0, 99) < req_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
      req_bus.valid <= 1'b1;
      req_bus.operation <= op;
      req_bus.mac <= mac;
      req_bus.peer_addr <= addr;
      req_bus.peer_port <= port;
      items_offered++;
      do @(posedge clock); while (!req_bus.ready);
   endtask

   task automatic settle();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
   endtask

   // Registers are only written with nothing in flight.
   task automatic set_expiry(input logic [EXPIRY_W-1:0] value);
      settle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_EXPIRY_ADDR;
      csr_pwdata <= CSR_DATA_W'(value);
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Mostly traffic among a small set of stations, so that the table fills, entries
   // age out and slots get reused; the rest are group addresses and stray MACs.
   task automatic random_item(output bit counted);
      logic [OP_W-1:0]  op;
      logic [MAC_W-1:0] mac;
      int               pick;
      pick = $urandom_range(0, 99);
      if (pick < 38)
         op = OP_LEARN;
      else if (pick < 78)
         op = OP_LOOKUP;
      else if (pick < 97)
         op = OP_TICK;
      else
         op = OP_UNUSED;
      pick = $urandom_range(0, 99);
      mac = station_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (pick >= 92)
         mac = MAC_W'({$urandom, $urandom});
      else if (pick >= 85)
         mac = mac | GROUP_MASK;
      offer(op, mac, $urandom, PORT_W'($urandom));
      counted = !(op == OP_UNUSED || (op == OP_LEARN && mac[GROUP_BIT]));
   endtask

   initial begin : stimulus
      int phase;
      int done_items;
      int i;
      bit counted;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_TICK;
      req_bus.mac = '0;
      req_bus.peer_addr = '0;
      req_bus.peer_port = '0;
      csr_psel = 1'b0;
      csr_penable = 1'b0;
      csr_pwrite = 1'b0;
      csr_paddr = '0;
      csr_pwdata = '0;
      for (i = 0; i < POOL_SIZE; i++)
         station_pool[i] = MAC_W'({$urandom, $urandom}) & ~GROUP_MASK;
      expiry_plan[PHASES-1] = EXPIRY_W'($urandom_range(1, 65535));

      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part under the reset expiry setting.
      req_idle_pct = 20;
      rsp_idle_pct = 71;
      offer(OP_LOOKUP, '0, $urandom, PORT_W'($urandom));
      offer(OP_LEARN, '0, '0, '0);
      offer(OP_LOOKUP, '0, $urandom, PORT_W'($urandom));
      offer(OP_LEARN, ALL_ONES_MAC, '1, '1);
      offer(OP_LOOKUP, ALL_ONES_MAC, '1, '1);
      offer(OP_LEARN, TOP_UNICAST, '1, '1);
      offer(OP_LOOKUP, TOP_UNICAST, '0, '0);
      offer(OP_LEARN, '0, 32'h0A00_0001, 16'd4789);
      offer(OP_LOOKUP, '0, '0, '0);
      offer(OP_TICK, '0, '0, '0);
      offer(OP_TICK, ALL_ONES_MAC, '1, '1);
      offer(OP_UNUSED, MAC_W'({$urandom, $urandom}), $urandom, PORT_W'($urandom));
      offer(OP_LOOKUP, GROUP_ONLY, '0, '0);
      offer(OP_LEARN, GROUP_ONLY, $urandom, PORT_W'($urandom));

      // With a zero expiry the first lookup still forwards, the second floods.
      set_expiry('0);
      offer(OP_LEARN, STATION_A, 32'hC0A8_0101, 16'd5000);
      offer(OP_LOOKUP, STATION_A, '0, '0);
      offer(OP_LOOKUP, STATION_A, '0, '0);
      offer(OP_LEARN, STATION_A, 32'hC0A8_0102, 16'd5001);
      offer(OP_LOOKUP, STATION_A, '0, '0);
      offer(OP_TICK, '0, '0, '0);
      offer(OP_LOOKUP, STATION_A, '0, '0);

      for (phase = 0; phase < PHASES; phase++) begin
         req_idle_pct = (phase < 2) ? 20 : (phase < 4) ? 71 : 0;
         rsp_idle_pct = (phase < 2) ? 71 : (phase < 4) ? 20 : 0;
         set_expiry(expiry_plan[phase]);
         // With no idling on either side, a long output stall backs the block up.
         if (phase == 4)
            hold_requests++;
         done_items = 0;
         while (done_items < ITEMS_PER_PHASE) begin
            random_item(counted);
            if (counted)
               done_items++;
            if (phase == 2 && counted && done_items == ITEMS_PER_PHASE / 2)
               settle();
         end
      end

      settle();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d transactions across %0d expiry settings and a long result stall.",
               items_offered, PHASES + 2);
      $display("Results seen: %0d forwarded, %0d flooded, %0d learns rejected, %0d completed.",
               sends_seen, floods_seen, rejects_seen, dones_seen);
      if (failures == 0 && outstanding == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end

   initial begin
      #3_000_000;
      $display("Timed out with %0d results still outstanding.", outstanding);
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule

@@ mac_learning_forward_table.f @@
rtl/core/mlft_pkg.sv
rtl/core/mlft_if.sv
rtl/core/mlft_ram.sv
rtl/core/mac_learning_forward_table.sv
dv/mlft_checker.sv
dv/tb_top.sv
